// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the checker of this block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset
`define IAS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the block clock clk_i and reset rst_ni
`define IAS_ASSERT_DEF(lbl, prop, msg) \
  `IAS_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== src/ias_pkg.sv =====
// ----------------------------------------------------------------------------
// ias_pkg
// Types and field widths shared by the interval activity selector files.
// ----------------------------------------------------------------------------
`default_nettype none

package ias_pkg;

  localparam int unsigned TimeW = 16;
  localparam int unsigned NumW  = 7;

  typedef logic [TimeW-1:0] time_t;
  typedef logic [NumW-1:0]  num_t;

endpackage

`default_nettype wire

// ===== src/ias_in_if.sv =====
// ----------------------------------------------------------------------------
// ias_in_if
// Valid/ready channel that carries one meeting interval per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface ias_in_if;

  logic          valid;
  logic          ready;
  ias_pkg::time_t start_time;
  ias_pkg::time_t finish_time;
  logic          final_entry;

  modport source (output valid, output start_time, output finish_time,
                  output final_entry, input ready);
  modport sink   (input valid, input start_time, input finish_time,
                  input final_entry, output ready);

endinterface

`default_nettype wire

// ===== src/ias_out_if.sv =====
// ----------------------------------------------------------------------------
// ias_out_if
// Valid/ready channel that carries one selected meeting number per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface ias_out_if;

  logic          valid;
  logic          ready;
  ias_pkg::num_t meeting_number;
  logic          last_of_run;

  modport source (output valid, output meeting_number, output last_of_run,
                  input ready);
  modport sink   (input valid, input meeting_number, input last_of_run,
                  output ready);

endinterface

`default_nettype wire

// ===== src/interval_activity_selector.sv =====
// Load: one interval per cycle is taken while loading; items beyond MAX_MEETINGS are dropped.
// Selection after the final item runs n scan passes for n stored intervals, each reading
//   every stored entry from the memory with registered read data, then a decide state.
// Emission walks the chosen map one position per cycle while the output stage is free;
//   input is taken again once the last result is in the output stage.
// Reset clears all control state and the chosen map; the interval memory is not cleared.
// ----------------------------------------------------------------------------
// interval_activity_selector
// Greedy activity selection over a set of meeting intervals held in a memory.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_activity_selector #(
  parameter int unsigned MAX_MEETINGS = 64
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  ias_in_if.sink     in_i,
  ias_out_if.source  out_o
);

  localparam int unsigned IdxW = (MAX_MEETINGS > 1) ? $clog2(MAX_MEETINGS) : 1;
  localparam int unsigned CntW = $clog2(MAX_MEETINGS + 1);
  localparam int unsigned TW   = ias_pkg::TimeW;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT
  } state_e;

  state_e              state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [CntW-1:0]     n_q, n_d;
  logic [IdxW-1:0]     addr_q, addr_d;
  logic                iss_q, iss_d;
  logic                rv_q, rv_d;
  logic [IdxW-1:0]     ridx_q, ridx_d;
  logic [IdxW-1:0]     pass_q, pass_d;
  logic                first_q, first_d;
  logic                bhave_q, bhave_d;
  ias_pkg::time_t      bfin_q, bfin_d;
  ias_pkg::time_t      bsta_q, bsta_d;
  logic [IdxW-1:0]     bidx_q, bidx_d;
  ias_pkg::time_t      cfin_q, cfin_d;
  logic [IdxW-1:0]     cidx_q, cidx_d;
  ias_pkg::time_t      lfin_q, lfin_d;
  logic [MAX_MEETINGS-1:0] map_q, map_d;
  logic [IdxW-1:0]     eidx_q, eidx_d;
  logic                ovalid_q, ovalid_d;
  ias_pkg::num_t       onum_q, onum_d;
  logic                olast_q, olast_d;

  // Interval memory: {start, finish} per entry
  logic [2*TW-1:0]     mem_q [MAX_MEETINGS];
  logic [2*TW-1:0]     rdata_q;
  logic                mem_we, mem_re;
  logic [IdxW-1:0]     mem_wa, mem_ra;

  logic                in_xfer;
  logic                slot_free;
  logic [IdxW-1:0]     last_idx;
  ias_pkg::time_t      rd_fin, rd_sta;
  logic                cand;
  logic                take;
  logic [MAX_MEETINGS-1:0] map_rest;
  logic                is_last;

  assign in_i.ready           = (state_q == ST_LOAD);
  assign in_xfer              = in_i.valid && in_i.ready;
  assign slot_free            = !ovalid_q || out_o.ready;
  assign last_idx             = IdxW'(n_q - CntW'(1));
  assign rd_fin               = rdata_q[TW-1:0];
  assign rd_sta               = rdata_q[2*TW-1:TW];
  assign out_o.valid          = ovalid_q;
  assign out_o.meeting_number = onum_q;
  assign out_o.last_of_run    = olast_q;

  // Successor test in (finish, position) order relative to the cursor
  assign cand = first_q || (rd_fin > cfin_q) || ((rd_fin == cfin_q) && (ridx_q > cidx_q));
  // Greedy acceptance of the best candidate of a pass
  assign take = first_q || (bsta_q > lfin_q);

  // Chosen map with the position under the emit pointer removed
  always_comb begin
    map_rest         = map_q;
    map_rest[eidx_q] = 1'b0;
  end
  assign is_last = ~|map_rest;

  // Next-state logic
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    n_d      = n_q;
    addr_d   = addr_q;
    iss_d    = iss_q;
    rv_d     = 1'b0;
    ridx_d   = ridx_q;
    pass_d   = pass_q;
    first_d  = first_q;
    bhave_d  = bhave_q;
    bfin_d   = bfin_q;
    bsta_d   = bsta_q;
    bidx_d   = bidx_q;
    cfin_d   = cfin_q;
    cidx_d   = cidx_q;
    lfin_d   = lfin_q;
    map_d    = map_q;
    eidx_d   = eidx_q;
    ovalid_d = ovalid_q && !out_o.ready;
    onum_d   = onum_q;
    olast_d  = olast_q;
    mem_we   = 1'b0;
    mem_wa   = cnt_q[IdxW-1:0];
    mem_re   = 1'b0;
    mem_ra   = addr_q;

    unique case (state_q)
      ST_LOAD: begin
        if (in_xfer) begin
          // Store while there is room; drop the item otherwise
          if (cnt_q < CntW'(MAX_MEETINGS)) begin
            mem_we = 1'b1;
            cnt_d  = cnt_q + CntW'(1);
          end
          if (in_i.final_entry) begin
            n_d     = (cnt_q < CntW'(MAX_MEETINGS)) ? cnt_q + CntW'(1) : cnt_q;
            cnt_d   = '0;
            addr_d  = '0;
            iss_d   = 1'b1;
            pass_d  = '0;
            first_d = 1'b1;
            bhave_d = 1'b0;
            map_d   = '0;
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Issue one read per cycle over the stored entries
        if (iss_q) begin
          mem_re = 1'b1;
          rv_d   = 1'b1;
          ridx_d = addr_q;
          if (addr_q == last_idx) begin
            iss_d = 1'b0;
          end else begin
            addr_d = addr_q + IdxW'(1);
          end
        end
        // Keep the smallest successor of the cursor
        if (rv_q) begin
          if (cand && (!bhave_q || (rd_fin < bfin_q))) begin
            bhave_d = 1'b1;
            bfin_d  = rd_fin;
            bsta_d  = rd_sta;
            bidx_d  = ridx_q;
          end
          if (ridx_q == last_idx) begin
            state_d = ST_DECIDE;
          end
        end
      end

      ST_DECIDE: begin
        if (take) begin
          map_d[bidx_q] = 1'b1;
          lfin_d        = bfin_q;
        end
        // Advance the cursor to this pass's interval
        cfin_d  = bfin_q;
        cidx_d  = bidx_q;
        first_d = 1'b0;
        bhave_d = 1'b0;
        if (pass_q == last_idx) begin
          eidx_d  = '0;
          state_d = ST_EMIT;
        end else begin
          pass_d  = pass_q + IdxW'(1);
          addr_d  = '0;
          iss_d   = 1'b1;
          state_d = ST_SCAN;
        end
      end

      ST_EMIT: begin
        // Walk the map in ascending position, one per cycle when the stage is free
        if (slot_free) begin
          eidx_d = eidx_q + IdxW'(1);
          if (map_q[eidx_q]) begin
            ovalid_d      = 1'b1;
            onum_d        = ias_pkg::NumW'(eidx_q) + ias_pkg::NumW'(1);
            olast_d       = is_last;
            map_d[eidx_q] = 1'b0;
            if (is_last) begin
              state_d = ST_LOAD;
            end
          end
        end
      end

      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // Interval memory with registered read data
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= {in_i.start_time, in_i.finish_time};
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_ra];
    end
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      cnt_q    <= '0;
      n_q      <= '0;
      addr_q   <= '0;
      iss_q    <= 1'b0;
      rv_q     <= 1'b0;
      ridx_q   <= '0;
      pass_q   <= '0;
      first_q  <= 1'b1;
      bhave_q  <= 1'b0;
      bfin_q   <= '0;
      bsta_q   <= '0;
      bidx_q   <= '0;
      cfin_q   <= '0;
      cidx_q   <= '0;
      lfin_q   <= '0;
      map_q    <= '0;
      eidx_q   <= '0;
      ovalid_q <= 1'b0;
      onum_q   <= '0;
      olast_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      n_q      <= n_d;
      addr_q   <= addr_d;
      iss_q    <= iss_d;
      rv_q     <= rv_d;
      ridx_q   <= ridx_d;
      pass_q   <= pass_d;
      first_q  <= first_d;
      bhave_q  <= bhave_d;
      bfin_q   <= bfin_d;
      bsta_q   <= bsta_d;
      bidx_q   <= bidx_d;
      cfin_q   <= cfin_d;
      cidx_q   <= cidx_d;
      lfin_q   <= lfin_d;
      map_q    <= map_d;
      eidx_q   <= eidx_d;
      ovalid_q <= ovalid_d;
      onum_q   <= onum_d;
      olast_q  <= olast_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/ias_checker.sv =====
// ----------------------------------------------------------------------------
// ias_checker
// Port-level checks of the interval activity selector, bound into the selector module.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ias_checker #(
  parameter int unsigned MAX_MEETINGS = 64
) (
  input wire         clk_i,
  input wire         rst_ni,
  ias_in_if.sink     in_i,
  ias_out_if.source  out_o
);

  // Hold a stalled result
  `IAS_ASSERT_DEF(a_out_hold, out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.meeting_number) && $stable(out_o.last_of_run), "stalled result changed")

  // Close input after the final interval
  `IAS_ASSERT_DEF(a_final_closes, in_i.valid && in_i.ready && in_i.final_entry |=> !in_i.ready, "input still open after final interval")

  // Keep input closed until the last result of a run is staged
  `IAS_ASSERT_DEF(a_run_blocks, out_o.valid && !out_o.last_of_run |-> !in_i.ready, "input open during emission")

  // Report only positions from 1 to MAX_MEETINGS
  `IAS_ASSERT_DEF(a_num_range, out_o.valid |-> (out_o.meeting_number != 7'd0) && (out_o.meeting_number <= 7'(MAX_MEETINGS)), "meeting number out of range")

endmodule

bind interval_activity_selector ias_checker #(
  .MAX_MEETINGS(MAX_MEETINGS)
) u_ias_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .out_o  (out_o)
);

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: interval_activity_selector testbench
// Sends sets of meeting intervals and predicts the greedy selection of each
// set. Every selected meeting that comes out is compared with the oldest
// prediction. Both channels idle at random. The run covers singleton sets,
// ties, overlaps, full sets and sets that overflow the interval store.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxSet       = 64;
  localparam int NumDirected  = 19;
  localparam int RandomItems  = 360;
  localparam int TailCycles   = 40;

  typedef struct packed {
    ias_pkg::num_t number;
    logic          last;
  } meeting_pick_t;

  typedef struct packed {
    ias_pkg::time_t start;
    ias_pkg::time_t finish;
    logic           fin;
    bit             typed;
    ias_pkg::num_t  number;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ias_in_if  in_if ();
  ias_out_if out_if ();

  interval_activity_selector #(
    .MAX_MEETINGS(MaxSet)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Predictor state: intervals of the open set
  ias_pkg::time_t held_start [MaxSet];
  ias_pkg::time_t held_finish[MaxSet];
  int             held_count = 0;

  meeting_pick_t picks_due[$];
  meeting_pick_t due_pick;

  int  failures      = 0;
  int  items_stored  = 0;
  int  sets_closed   = 0;
  int  full_sets     = 0;
  int  overflow_sets = 0;
  int  picks_checked = 0;
  bit  gaps_on       = 1'b1;

  // Directed intervals; a typed number marks a singleton set
  plan_row_t plan [NumDirected] = '{
    '{16'h0000, 16'h0000, 1'b1, 1'b1, 7'd1},
    '{16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 7'd1},
    '{16'h1234, 16'h0000, 1'b1, 1'b1, 7'd1},
    '{16'h0005, 16'h000A, 1'b0, 1'b0, 7'd0},
    '{16'h0000, 16'h0003, 1'b0, 1'b0, 7'd0},
    '{16'h000B, 16'h0014, 1'b1, 1'b0, 7'd0},
    '{16'h0001, 16'h0007, 1'b0, 1'b0, 7'd0},
    '{16'h0002, 16'h0007, 1'b0, 1'b0, 7'd0},
    '{16'h0008, 16'h0008, 1'b1, 1'b0, 7'd0},
    '{16'h0000, 16'h0005, 1'b0, 1'b0, 7'd0},
    '{16'h0005, 16'h0009, 1'b1, 1'b0, 7'd0},
    '{16'hFFFF, 16'h0000, 1'b0, 1'b0, 7'd0},
    '{16'h0000, 16'hFFFF, 1'b1, 1'b0, 7'd0},
    '{16'h0000, 16'hFFFF, 1'b0, 1'b0, 7'd0},
    '{16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 7'd0},
    '{16'h0001, 16'h0001, 1'b1, 1'b0, 7'd0},
    '{16'h5555, 16'hAAAA, 1'b0, 1'b0, 7'd0},
    '{16'hAAAA, 16'h5555, 1'b0, 1'b0, 7'd0},
    '{16'hFFFE, 16'hFFFF, 1'b1, 1'b0, 7'd0}
  };

  // Clock
  always #4 clk_i = ~clk_i;

  // Append one expected meeting to the prediction queue
  function automatic void queue_pick(input ias_pkg::num_t number, input logic last);
    meeting_pick_t pick;
    pick.number = number;
    pick.last   = last;
    picks_due   = {picks_due, pick};
  endfunction

  // Store one interval; on the closing item return the map of chosen positions
  function automatic logic [63:0] select_meetings(input ias_pkg::time_t s,
                                                  input ias_pkg::time_t f,
                                                  input logic fin);
    int             order[MaxSet];
    int             n;
    int             i;
    int             j;
    int             k;
    ias_pkg::time_t bound;
    logic [63:0]    chosen;
    if (held_count < MaxSet) begin
      held_start[held_count]  = s;
      held_finish[held_count] = f;
      held_count++;
    end
    if (!fin) return '0;
    n = held_count;
    // Sort by finish time, equal finishes keep input order
    for (i = 0; i < n; i++) begin
      j = i;
      while (j > 0 && held_finish[order[j-1]] > held_finish[i]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    // Take the earliest finish, then every interval starting strictly after
    chosen           = '0;
    chosen[order[0]] = 1'b1;
    bound            = held_finish[order[0]];
    for (i = 1; i < n; i++) begin
      k = order[i];
      if (held_start[k] > bound) begin
        chosen[k] = 1'b1;
        bound     = held_finish[k];
      end
    end
    held_count = 0;
    return chosen;
  endfunction

  // Drive one interval, wait for its transfer and queue what it selects
  task automatic send_interval(input ias_pkg::time_t s, input ias_pkg::time_t f,
                               input logic fin, input bit typed,
                               input ias_pkg::num_t typed_number);
    int          gap;
    int          top;
    int          i;
    logic [63:0] chosen;
    gap = gaps_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid       = 1'b1;
    in_if.start_time  = s;
    in_if.finish_time = f;
    in_if.final_entry = fin;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (held_count < MaxSet) items_stored++;
    if (held_count == MaxSet - 1 || (held_count == MaxSet && fin)) begin
      if (held_count == MaxSet - 1 && fin) full_sets++;
    end
    chosen = select_meetings(s, f, fin);
    if (fin) begin
      sets_closed++;
      if (typed) begin
        queue_pick(typed_number, 1'b1);
      end else begin
        top = 0;
        for (i = 0; i < MaxSet; i++) if (chosen[i]) top = i;
        for (i = 0; i < MaxSet; i++) begin
          if (chosen[i]) queue_pick(ias_pkg::num_t'(i + 1), i == top);
        end
      end
    end
    @(negedge clk_i);
  endtask

  // Hold the input idle until every predicted meeting has come out
  task automatic drain_picks();
    in_if.valid = 1'b0;
    while (picks_due.size() != 0) @(negedge clk_i);
  endtask

  // Compare each output transfer with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (picks_due.size() == 0) begin
        $error("unexpected result: meeting_number %0d last_of_run %0b",
               out_if.meeting_number, out_if.last_of_run);
        failures++;
      end else begin
        due_pick = picks_due.pop_front();
        picks_checked++;
        if (out_if.meeting_number !== due_pick.number) begin
          $error("meeting_number: expected %0d, got %0d",
                 due_pick.number, out_if.meeting_number);
          failures++;
        end
        if (out_if.last_of_run !== due_pick.last) begin
          $error("last_of_run: expected %0b, got %0b",
                 due_pick.last, out_if.last_of_run);
          failures++;
        end
      end
    end
  end

  // Output side: random stalls with calm stretches in between
  initial begin
    int stall;
    int calm_left;
    bit stalls_on;
    calm_left    = 0;
    stalls_on    = 1'b1;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (calm_left == 0) begin
        stalls_on = $urandom_range(0, 2) != 0;
        calm_left = $urandom_range(4, 24);
      end
      calm_left--;
      stall = stalls_on ? $urandom_range(0, 11) : 0;
      @(negedge clk_i);
      if (stall > 0) begin
        out_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready = 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
    end
  end

  // Main sequence
  initial begin
    int             d;
    int             k;
    int             r;
    int             set_size;
    int             remaining;
    int             style;
    ias_pkg::time_t s;
    ias_pkg::time_t f;
    in_if.valid       = 1'b0;
    in_if.start_time  = '0;
    in_if.finish_time = '0;
    in_if.final_entry = 1'b0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed intervals
    for (d = 0; d < NumDirected; d++) begin
      send_interval(plan[d].start, plan[d].finish, plan[d].fin, plan[d].typed,
                    plan[d].number);
    end
    drain_picks();

    // Random sets: mostly small, a few full and a few overflowing the store
    while (items_stored < NumDirected + RandomItems) begin
      r = $urandom_range(0, 99);
      if (r < 70)      set_size = $urandom_range(1, 8);
      else if (r < 88) set_size = $urandom_range(9, 24);
      else if (r < 95) set_size = MaxSet;
      else             set_size = MaxSet + $urandom_range(1, 5);
      // Trim the last set to the item budget
      remaining = NumDirected + RandomItems - items_stored;
      if (set_size > remaining) set_size = remaining;
      if (set_size > MaxSet) overflow_sets++;
      r = $urandom_range(0, 9);
      if (r < 5)      style = 1;
      else if (r < 7) style = 2;
      else if (r < 9) style = 0;
      else            style = 3;
      gaps_on = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 9) == 0) drain_picks();
      for (k = 0; k < set_size; k++) begin
        case (style)
          0: begin
            s = ias_pkg::time_t'($urandom_range(0, 16'hFFFF));
            f = ias_pkg::time_t'($urandom_range(0, 16'hFFFF));
          end
          1: begin
            s = ias_pkg::time_t'($urandom_range(0, 400));
            f = s + ias_pkg::time_t'($urandom_range(0, 40));
          end
          2: begin
            s = ias_pkg::time_t'($urandom_range(0, 7));
            f = ias_pkg::time_t'($urandom_range(0, 7));
          end
          default: begin
            s = ias_pkg::time_t'($urandom_range(16'hFFC0, 16'hFFFF));
            f = ias_pkg::time_t'($urandom_range(s, 16'hFFFF));
          end
        endcase
        send_interval(s, f, k == set_size - 1, 1'b0, '0);
      end
    end

    // Wait for the last selections, then watch for stray output
    drain_picks();
    repeat (TailCycles) @(negedge clk_i);

    $display("Stored %0d intervals in %0d sets (%0d full, %0d overflowing).",
             items_stored, sets_closed, full_sets, overflow_sets);
    $display("Checked %0d selected meetings.", picks_checked);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/ias_pkg.sv
src/ias_in_if.sv
src/ias_out_if.sv
src/interval_activity_selector.sv
src/ias_checker.sv
sim/tb.sv
